// ----- rtl/ppid_pkg.sv -----
// Shared constants, types and helpers of the positional PID controller.
`default_nettype none

package ppid_pkg;

    localparam int GAIN_FRAC   = 8;
    localparam int BLEND_FRAC  = 16;

    localparam int MUL_A_W     = 35;
    localparam int MUL_B_W     = 18;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

    localparam int DIV_DVD_W   = 48;
    localparam int DIV_Q_W     = 33;
    localparam int DIV_D_W     = 16;
    localparam int DIV_CNT_W   = $clog2(DIV_Q_W + 1);

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 48;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DBAND  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ILIM   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OLIM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VRATE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FILT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd6;

    localparam int MODE_TRAP   = 0;
    localparam int MODE_VRATE  = 1;
    localparam int MODE_CLAMP  = 2;
    localparam int MODE_DMEAS  = 3;
    localparam int MODE_DFILT  = 4;
    localparam int MODE_OFILT  = 5;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
        logic signed [31:0] r;
        if (x[35:31] == 5'b00000 || x[35:31] == 5'b11111)
        begin
            r = x[31:0];
        end
        else if (x[35])
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ppid_if.sv -----
// Sample and drive channel interfaces of the positional PID controller.
`default_nettype none

interface ppid_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] measured_value;
    logic signed [15:0] setpoint;

    modport source (output valid, output measured_value, output setpoint, input ready);
    modport sink   (input valid, input measured_value, input setpoint, output ready);
endinterface

interface ppid_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] drive_value;
    logic               held_in_deadband;

    modport source (output valid, output drive_value, output held_in_deadband, input ready);
    modport sink   (input valid, input drive_value, input held_in_deadband, output ready);
endinterface

`default_nettype wire

// ----- rtl/ppid_mul.sv -----
// Shared signed multiplier with a registered product.
`default_nettype none

module ppid_mul (
    input  logic                                clk,
    input  logic signed [ppid_pkg::MUL_A_W-1:0] a,
    input  logic signed [ppid_pkg::MUL_B_W-1:0] b,
    output logic signed [ppid_pkg::MUL_P_W-1:0] p
);

    always_ff @(posedge clk)
    begin
        p <= a * b;
    end

endmodule

`default_nettype wire

// ----- rtl/ppid_div.sv -----
// Restoring divider, one quotient bit per cycle, for the changing integral rate.
`default_nettype none

module ppid_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [ppid_pkg::DIV_DVD_W-1:0]      dividend,
    input  logic [ppid_pkg::DIV_D_W-1:0]        divisor,
    output logic [ppid_pkg::DIV_Q_W-1:0]        quotient,
    output ppid_pkg::div_stat_t                 stat
);
    import ppid_pkg::*;

    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_Q_W-1:0]   dvd_reg;
    logic [DIV_Q_W-1:0]   q_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_D_W:0]     trial;
    logic [DIV_D_W:0]     diff;
    logic                 fits;

    assign trial = {rem_reg, dvd_reg[DIV_Q_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_Q_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= DIV_D_W'(dividend >> DIV_Q_W);
            dvd_reg <= dividend[DIV_Q_W-1:0];
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
            dvd_reg <= {dvd_reg[DIV_Q_W-2:0], 1'b0};
            q_reg   <= {q_reg[DIV_Q_W-2:0], fits};
        end
    end

    assign quotient  = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// ----- rtl/positional_pid_controller.sv -----
// Positional PID controller top level: sequencer around a shared multiplier and divider.
// A sample held in the deadband skips to the result; any other sample runs the
// proportional, derivative and integral steps, with extra states for derivative on
// measurement, the derivative filter, the output filter and the integral rate division.
// The multiplier and the sequencer serve one sample at a time, and a finished drive beat
// waits in its own register.
// Reset clears the configuration to its defaults, the controller history and the FSM.

`default_nettype none

module positional_pid_controller (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [ppid_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ppid_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    ppid_in_if.sink                              sample,
    ppid_out_if.source                           drive
);
    import ppid_pkg::*;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_P    = 5'd1;
    localparam logic [4:0] ST_D    = 5'd2;
    localparam logic [4:0] ST_I    = 5'd3;
    localparam logic [4:0] ST_R    = 5'd4;
    localparam logic [4:0] ST_RM   = 5'd5;
    localparam logic [4:0] ST_DIV  = 5'd6;
    localparam logic [4:0] ST_CL   = 5'd7;
    localparam logic [4:0] ST_DM   = 5'd8;
    localparam logic [4:0] ST_DF0  = 5'd9;
    localparam logic [4:0] ST_DF1  = 5'd10;
    localparam logic [4:0] ST_DF2  = 5'd11;
    localparam logic [4:0] ST_SUM  = 5'd12;
    localparam logic [4:0] ST_OF0  = 5'd13;
    localparam logic [4:0] ST_OF1  = 5'd14;
    localparam logic [4:0] ST_OF2  = 5'd15;
    localparam logic [4:0] ST_LIM  = 5'd16;
    localparam logic [4:0] ST_DONE = 5'd17;

    logic [47:0] gain_reg;
    logic [15:0] dband_reg;
    logic [15:0] ilim_reg;
    logic [14:0] olim_reg;
    logic [31:0] vrate_reg;
    logic [31:0] filt_reg;
    logic [5:0]  mode_reg;

    logic signed [16:0] prev_err_reg;
    logic signed [15:0] prev_meas_reg;
    logic signed [31:0] prev_deriv_reg;
    logic signed [15:0] prev_out_reg;
    logic signed [31:0] integ_reg;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    logic signed [16:0]  err_reg;
    logic signed [16:0]  dmeas_reg;
    logic signed [24:0]  pout_reg;
    logic signed [25:0]  dout_e_reg;
    logic signed [33:0]  dout_reg;
    logic signed [33:0]  iprod_reg;
    logic signed [33:0]  outv_reg;
    logic signed [MUL_P_W-1:0] acc_reg;
    logic                neg_reg;
    logic signed [15:0]  res_reg;
    logic                res_held_reg;
    logic signed [15:0]  out_drive_reg;
    logic                out_held_reg;
    logic                out_valid_reg;

    logic signed [15:0]  kp;
    logic signed [15:0]  ki;
    logic signed [15:0]  kd;
    logic [16:0]         aerr;
    logic signed [17:0]  err_diff;
    logic signed [17:0]  err_sum;
    logic [16:0]         ab_sum;
    logic signed [17:0]  factor;
    logic                err_int_same;
    logic                vr_cond;
    logic                in_band;
    logic signed [17:0]  cd_w;
    logic signed [17:0]  cd_inv;
    logic signed [17:0]  co_w;
    logic signed [17:0]  co_inv;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;
    logic [MUL_P_W-1:0]        prod_abs;
    logic signed [MUL_P_W-1:0] blend_sum;

    logic                 div_start;
    logic [DIV_Q_W-1:0]   quotient;
    div_stat_t            div_stat;

    logic signed [33:0] iterm_raw;
    logic signed [33:0] iterm_f;
    logic signed [34:0] iacc_f;
    logic signed [34:0] tmp_i;
    logic signed [34:0] tmp_o;
    logic signed [34:0] lim35;
    logic signed [34:0] neg_lim35;
    logic signed [34:0] omax35;
    logic signed [34:0] neg_omax35;
    logic signed [31:0] int_sum;
    logic signed [31:0] dsat;
    logic signed [33:0] omax34;
    logic signed [33:0] neg_omax34;
    logic               out_load;

    function automatic logic signed [15:0] res_reg_next_lim(input logic signed [33:0] v,
                                                            input logic signed [33:0] hi,
                                                            input logic signed [33:0] lo);
        logic signed [15:0] r;
        if (v > hi)
        begin
            r = 16'(hi);
        end
        else if (v < lo)
        begin
            r = 16'(lo);
        end
        else
        begin
            r = 16'(v);
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= '0;
            dband_reg <= '0;
            ilim_reg  <= '0;
            olim_reg  <= 15'h7FFF;
            vrate_reg <= '0;
            filt_reg  <= 32'hFFFF_FFFF;
            mode_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAIN:  gain_reg  <= cfg_wdata[47:0];
                REG_DBAND: dband_reg <= cfg_wdata[15:0];
                REG_ILIM:  ilim_reg  <= cfg_wdata[15:0];
                REG_OLIM:  olim_reg  <= cfg_wdata[14:0];
                REG_VRATE: vrate_reg <= cfg_wdata[31:0];
                REG_FILT:  filt_reg  <= cfg_wdata[31:0];
                REG_MODE:  mode_reg  <= cfg_wdata[5:0];
                default:   ;
            endcase
        end
    end

    assign kp = gain_reg[15:0];
    assign ki = gain_reg[31:16];
    assign kd = gain_reg[47:32];

    assign aerr     = err_reg[16] ? 17'(-err_reg) : 17'(err_reg);
    assign err_diff = 18'(err_reg) - 18'(prev_err_reg);
    assign err_sum  = 18'(err_reg) + 18'(prev_err_reg);
    assign ab_sum   = {1'b0, vrate_reg[15:0]} + {1'b0, vrate_reg[31:16]};
    assign factor   = 18'(ab_sum - aerr);

    assign err_int_same = (!err_reg[16] && err_reg != '0 && !integ_reg[31] && integ_reg != '0)
                        || (err_reg[16] && integ_reg[31]);
    assign vr_cond  = mode_reg[MODE_VRATE] && err_int_same && aerr > {1'b0, vrate_reg[31:16]};
    assign in_band  = aerr <= ab_sum && vrate_reg[15:0] != '0;

    assign cd_w   = {2'b00, filt_reg[31:16]};
    assign cd_inv = 18'h10000 - cd_w;
    assign co_w   = {2'b00, filt_reg[15:0]};
    assign co_inv = 18'h10000 - co_w;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_P:
            begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = MUL_B_W'(kp);
            end
            ST_D:
            begin
                mul_a = MUL_A_W'(err_diff);
                mul_b = MUL_B_W'(kd);
            end
            ST_I:
            begin
                mul_a = mode_reg[MODE_TRAP] ? MUL_A_W'(err_sum) : MUL_A_W'(err_reg);
                mul_b = MUL_B_W'(ki);
            end
            ST_R:
            begin
                mul_a = MUL_A_W'(prod);
                mul_b = factor;
            end
            ST_CL:
            begin
                mul_a = MUL_A_W'(dmeas_reg);
                mul_b = MUL_B_W'(kd);
            end
            ST_DF0:
            begin
                mul_a = MUL_A_W'(dout_reg);
                mul_b = cd_w;
            end
            ST_DF1:
            begin
                mul_a = MUL_A_W'(prev_deriv_reg);
                mul_b = cd_inv;
            end
            ST_OF0:
            begin
                mul_a = MUL_A_W'(outv_reg);
                mul_b = co_w;
            end
            ST_OF1:
            begin
                mul_a = MUL_A_W'(prev_out_reg);
                mul_b = co_inv;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    ppid_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    assign prod_abs  = prod[MUL_P_W-1] ? MUL_P_W'(-prod) : MUL_P_W'(prod);
    assign div_start = (state_reg == ST_RM);
    assign blend_sum = acc_reg + prod;

    ppid_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_abs[DIV_DVD_W-1:0]),
        .divisor  (vrate_reg[15:0]),
        .quotient (quotient),
        .stat     (div_stat)
    );

    assign iterm_raw  = mode_reg[MODE_TRAP] ? (iprod_reg >>> (GAIN_FRAC + 1))
                                            : (iprod_reg >>> GAIN_FRAC);
    assign tmp_i      = 35'(integ_reg) + 35'(iterm_raw);
    assign tmp_o      = 35'(pout_reg) + 35'(integ_reg) + 35'(dout_e_reg);
    assign lim35      = 35'({1'b0, ilim_reg});
    assign neg_lim35  = -lim35;
    assign omax35     = 35'({1'b0, olim_reg});
    assign neg_omax35 = -omax35;

    always_comb
    begin
        iterm_f = iterm_raw;
        iacc_f  = 35'(integ_reg);
        if (mode_reg[MODE_CLAMP])
        begin
            if ((tmp_o > omax35 || tmp_o < neg_omax35) && err_int_same)
            begin
                iterm_f = '0;
            end
            if (tmp_i > lim35)
            begin
                iterm_f = '0;
                iacc_f  = lim35;
            end
            if (tmp_i < neg_lim35)
            begin
                iterm_f = '0;
                iacc_f  = neg_lim35;
            end
        end
    end

    assign int_sum    = sat32(36'(iacc_f) + 36'(iterm_f));
    assign dsat       = sat32(36'(dout_reg));
    assign omax34     = 34'({1'b0, olim_reg});
    assign neg_omax34 = -omax34;
    assign out_load   = (state_reg == ST_DONE) && (!out_valid_reg || drive.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (sample.valid) state_next = ST_P;
            ST_P:    state_next = (aerr <= {1'b0, dband_reg}) ? ST_DONE : ST_D;
            ST_D:    state_next = ST_I;
            ST_I:    state_next = ST_R;
            ST_R:    state_next = (vr_cond && in_band) ? ST_RM : ST_CL;
            ST_RM:   state_next = ST_DIV;
            ST_DIV:  if (div_stat.done) state_next = ST_CL;
            ST_CL:   state_next = mode_reg[MODE_DMEAS] ? ST_DM : ST_DF0;
            ST_DM:   state_next = ST_DF0;
            ST_DF0:  state_next = mode_reg[MODE_DFILT] ? ST_DF1 : ST_SUM;
            ST_DF1:  state_next = ST_DF2;
            ST_DF2:  state_next = ST_SUM;
            ST_SUM:  state_next = mode_reg[MODE_OFILT] ? ST_OF0 : ST_LIM;
            ST_OF0:  state_next = ST_OF1;
            ST_OF1:  state_next = ST_OF2;
            ST_OF2:  state_next = ST_LIM;
            ST_LIM:  state_next = ST_DONE;
            ST_DONE: if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            prev_err_reg   <= '0;
            prev_meas_reg  <= '0;
            prev_deriv_reg <= '0;
            prev_out_reg   <= '0;
            integ_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                prev_meas_reg <= 16'(17'(prev_meas_reg) - dmeas_reg);
                prev_err_reg  <= err_reg;
            end
            else if (drive.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_CL)
            begin
                integ_reg <= int_sum;
            end
            if (state_reg == ST_SUM)
            begin
                prev_deriv_reg <= dsat;
            end
            if (state_reg == ST_LIM)
            begin
                prev_out_reg <= res_reg_next_lim(outv_reg, omax34, neg_omax34);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid)
                begin
                    err_reg   <= 17'(sample.setpoint) - 17'(sample.measured_value);
                    dmeas_reg <= 17'(prev_meas_reg) - 17'(sample.measured_value);
                end
            end
            ST_P:
            begin
                res_reg      <= prev_out_reg;
                res_held_reg <= 1'b1;
            end
            ST_D:    pout_reg   <= 25'(prod >>> GAIN_FRAC);
            ST_I:    dout_e_reg <= 26'(prod >>> GAIN_FRAC);
            ST_R:    iprod_reg  <= (vr_cond && !in_band) ? '0 : 34'(prod);
            ST_RM:   neg_reg    <= prod[MUL_P_W-1];
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    iprod_reg <= neg_reg ? -(34'(quotient)) : 34'(quotient);
                end
            end
            ST_CL:   dout_reg <= 34'(dout_e_reg);
            ST_DM:   dout_reg <= 34'(prod >>> GAIN_FRAC);
            ST_DF1:  acc_reg  <= prod;
            ST_DF2:  dout_reg <= 34'(blend_sum >>> BLEND_FRAC);
            ST_SUM:  outv_reg <= 34'(pout_reg) + 34'(integ_reg) + 34'(dsat);
            ST_OF1:  acc_reg  <= prod;
            ST_OF2:  outv_reg <= 34'(blend_sum >>> BLEND_FRAC);
            ST_LIM:
            begin
                res_reg      <= res_reg_next_lim(outv_reg, omax34, neg_omax34);
                res_held_reg <= 1'b0;
            end
            default: ;
        endcase
        if (out_load)
        begin
            out_drive_reg <= res_reg;
            out_held_reg  <= res_held_reg;
        end
    end

    assign sample.ready           = (state_reg == ST_IDLE);
    assign drive.valid            = out_valid_reg;
    assign drive.drive_value      = out_drive_reg;
    assign drive.held_in_deadband = out_held_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> state_reg == ST_P)
        else $error("accepted beat did not start the sequence");

    a_div_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DIV)
        else $error("divider finished outside its wait state");

    a_div_started: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RM |=> div_stat.busy)
        else $error("divider not busy after start");

    a_result_issued: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("finished result not presented");

endmodule

`default_nettype wire
